@@ hw/rtl/bcop_pkg.sv @@
// bcop_pkg: widths, reset values and small helpers for the centre of pressure block
// used by bcop_mul, bcop_div, biped_center_of_pressure and bcop_chk; no dependencies
package bcop_pkg;

  localparam int DATA_W     = 32;                 // q16.16 sample and result width
  localparam int FRAC_BITS  = 16;
  localparam int MF_W       = DATA_W - 1;         // load threshold register width
  localparam int CNT_W      = $clog2(DATA_W);     // multiplier step counter
  localparam int ACC_W      = 2 * DATA_W;         // numerator accumulator width
  localparam int QUOT_W     = DATA_W + 3;         // quotient bits kept before clamping
  localparam int HI_W       = ACC_W - QUOT_W;     // numerator bits above the quotient window
  localparam int DIV_W      = DATA_W + 1;         // divisor width (sum of two forces)
  localparam int QCNT_W     = $clog2(QUOT_W);     // divider step counter
  localparam int SUM_W      = QUOT_W + 2;         // position plus signed quotient

  localparam int IN_TDATA_W  = 8 * DATA_W;
  localparam int OUT_FIELD_W = 4 * DATA_W + 3;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [MF_W-1:0] MIN_FORCE_RST = MF_W'(655360);

  // magnitude of a two's complement word, the most negative value maps to 2^(w-1)
  function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

endpackage

@@ hw/rtl/bcop_mul.sv @@
// bcop_mul: bit-serial unsigned multiplier, one multiplier bit per cycle
// depends on bcop_pkg
module bcop_mul import bcop_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DATA_W-1:0]   a_mag,
  input  logic [DATA_W-1:0]   b_mag,
  output logic                done,
  output logic [ACC_W-1:0]    prod
);

  logic [DATA_W-1:0] mcand_r;
  logic [DATA_W-1:0] hi_r;
  logic [DATA_W-1:0] lo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   sum;

  // add the multiplicand when the current low bit is set, then shift right
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= a_mag;
      hi_r    <= '0;
      lo_r    <= b_mag;
    end else if (busy_r) begin
      hi_r <= sum[DATA_W:1];
      lo_r <= {sum[0], lo_r[DATA_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

@@ hw/rtl/bcop_div.sv @@
// bcop_div: restoring divider, one quotient bit per cycle, with overflow detect
// depends on bcop_pkg
module bcop_div import bcop_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ACC_W-1:0]   num_mag,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic               ovf,
  output logic [QUOT_W-1:0]  quot
);

  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [QUOT_W-1:0] q_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ovf_r;
  logic              ovf_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W+1:0]  diff;
  logic              ge;

  // quotient too wide for the window when the top bits already reach the divisor
  assign ovf_nxt = {{(DIV_W - HI_W){1'b0}}, num_mag[ACC_W-1:QUOT_W]} >= divisor;

  assign trial = {rem_r, q_r[QUOT_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign ge    = !diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !ovf_nxt;
        done_r <= ovf_nxt;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + QCNT_W'(1);
        if (cnt_r == QCNT_W'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r <= ovf_nxt;
      dvs_r <= divisor;
      rem_r <= {{(DIV_W - HI_W){1'b0}}, num_mag[ACC_W-1:QUOT_W]};
      q_r   <= num_mag[QUOT_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      q_r   <= {q_r[QUOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quot = q_r;

endmodule

@@ hw/rtl/biped_center_of_pressure.sv @@
// biped_center_of_pressure: per-foot and combined centre of pressure from f/t words
// depends on bcop_pkg, bcop_mul, bcop_div
//
// channel  dir  handshake               payload
// in_      in   in_tvalid / in_tready   tuser: cmd; tdata: pos x,y,z, torque x,y, force x,y,z
// out_     out  out_tvalid / out_tready tdata: foot valid,x,y, both valid,x,y, clipped
// cfg_     in   cfg_valid / cfg_ready   cfg_data: min_force (always ready)
//
// one word at a time; every coordinate pass runs bit-serial multiplies and a serial divide
// (one quotient bit each step) on shared units
// unloaded foot: straight to the output register; loaded foot: x and y passes; right foot
// with both loaded: two more passes with two products each
// synchronous active-low reset; stored left foot state clears to unloaded and zero
// a finished word waits in the output register; the next word is taken once it is placed
module biped_center_of_pressure import bcop_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pos_x, pos_y, pos_z, torque_x, torque_y,
                                             // force_x, force_y, force_z (32 bits each)
  input  logic                   in_tuser,   // cmd: 0 left foot, 1 right foot
  // result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // foot_valid, foot_x, foot_y, both_valid,
                                             // both_x, both_y, clipped, zero pad
  // threshold register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MF_W-1:0]        cfg_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_DGO   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // coordinate passes
  localparam logic [1:0] PASS_FX = 2'd0;
  localparam logic [1:0] PASS_FY = 2'd1;
  localparam logic [1:0] PASS_BX = 2'd2;
  localparam logic [1:0] PASS_BY = 2'd3;

  localparam logic CMD_RIGHT = 1'b1;

  logic [2:0]        state_r;
  logic [1:0]        pass_r;
  logic              term_r;
  logic [MF_W-1:0]   min_force_r;

  // latched sample
  logic              cmd_r, loaded_r;
  logic [DATA_W-1:0] px_r, py_r, pz_r, tx_r, ty_r, fx_r, fy_r, fz_r;

  // kept left foot result
  logic              lload_r;
  logic [DATA_W-1:0] lcx_r, lcy_r, lfz_r;

  // working results
  logic [DATA_W-1:0] cx_r, cy_r, bx_r, by_r;
  logic              both_r, clip_r;
  logic [ACC_W-1:0]  num_r;
  logic              prod_neg_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic              in_acc;
  logic              combined;
  logic              op_term;
  logic              mul_start, mul_done;
  logic [DATA_W-1:0] op_a, op_b;
  logic              op_sub;
  logic [ACC_W-1:0]  prod;
  logic              prod_neg;
  logic [ACC_W-1:0]  num_base;
  logic              num_neg;
  logic [ACC_W-1:0]  num_mag;
  logic [DIV_W-1:0]  divisor;
  logic              div_start, div_done, div_ovf;
  logic [QUOT_W-1:0] quot;
  logic [QUOT_W-1:0] q_mag;
  logic [SUM_W-1:0]  q_sgn;
  logic [SUM_W-1:0]  pos_ext;
  logic [SUM_W-1:0]  coord_sum;
  logic              coord_ovf;
  logic [DATA_W-1:0] coord_sat;
  logic              out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign combined  = (pass_r == PASS_BX) || (pass_r == PASS_BY);
  // the second product of the weighted mean is launched from the first accumulate cycle
  assign op_term   = term_r || (state_r == ST_ACC);

  // operands of the current product: pz times a horizontal force for one foot,
  // or a vertical force times a foot coordinate for the weighted mean
  always_comb begin
    op_a   = pz_r;
    op_b   = fx_r;
    op_sub = 1'b1;
    unique case (pass_r)
      PASS_FX: begin
        op_a = pz_r;  op_b = fx_r;  op_sub = 1'b1;
      end
      PASS_FY: begin
        op_a = pz_r;  op_b = fy_r;  op_sub = 1'b1;
      end
      PASS_BX: begin
        op_a = op_term ? fz_r : lfz_r;  op_b = op_term ? cx_r : lcx_r;  op_sub = 1'b0;
      end
      PASS_BY: begin
        op_a = op_term ? fz_r : lfz_r;  op_b = op_term ? cy_r : lcy_r;  op_sub = 1'b0;
      end
      default: begin
        op_a = pz_r;  op_b = fx_r;  op_sub = 1'b1;
      end
    endcase
  end

  // numerator starts from the torque term in q32.32, or zero for the weighted mean
  always_comb begin
    num_base = '0;
    if (pass_r == PASS_FX) begin
      num_base = ~{{(DATA_W - FRAC_BITS){ty_r[DATA_W-1]}}, ty_r, {FRAC_BITS{1'b0}}}
                 + ACC_W'(1);
    end else if (pass_r == PASS_FY) begin
      num_base = {{(DATA_W - FRAC_BITS){tx_r[DATA_W-1]}}, tx_r, {FRAC_BITS{1'b0}}};
    end
  end

  assign mul_start = (state_r == ST_SETUP) || (state_r == ST_ACC && combined && !term_r);
  assign prod_neg  = op_a[DATA_W-1] ^ op_b[DATA_W-1] ^ op_sub;

  bcop_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_mag (mag_of(op_a)),
    .b_mag (mag_of(op_b)),
    .done  (mul_done),
    .prod  (prod)
  );

  // divide the magnitude, sign restored afterwards so the quotient truncates to zero
  assign num_neg   = num_r[ACC_W-1];
  assign num_mag   = num_neg ? (~num_r + ACC_W'(1)) : num_r;
  assign divisor   = combined ? ({1'b0, lfz_r} + {1'b0, fz_r}) : {1'b0, fz_r};
  assign div_start = (state_r == ST_DGO);

  bcop_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (num_mag),
    .divisor (divisor),
    .done    (div_done),
    .ovf     (div_ovf),
    .quot    (quot)
  );

  // an overflowed quotient is clamped wide enough to saturate any position
  assign q_mag = div_ovf ? {QUOT_W{1'b1}} : quot;
  assign q_sgn = num_neg ? (~{2'b00, q_mag} + SUM_W'(1)) : {2'b00, q_mag};

  always_comb begin
    pos_ext = '0;
    if (pass_r == PASS_FX) begin
      pos_ext = {{(SUM_W - DATA_W){px_r[DATA_W-1]}}, px_r};
    end else if (pass_r == PASS_FY) begin
      pos_ext = {{(SUM_W - DATA_W){py_r[DATA_W-1]}}, py_r};
    end
  end

  assign coord_sum = pos_ext + q_sgn;
  // in range only when every bit above the sign matches it
  assign coord_ovf = (coord_sum[SUM_W-1:DATA_W-1] != {(SUM_W - DATA_W + 1){1'b0}}) &&
                     (coord_sum[SUM_W-1:DATA_W-1] != {(SUM_W - DATA_W + 1){1'b1}});
  assign coord_sat = !coord_ovf ? coord_sum[DATA_W-1:0] :
                     coord_sum[SUM_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}} :
                                          {1'b0, {(DATA_W - 1){1'b1}}};

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_force_r <= MIN_FORCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_force_r <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= PASS_FX;
      term_r  <= 1'b0;
      lload_r <= 1'b0;
      lcx_r   <= '0;
      lcy_r   <= '0;
      lfz_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            pass_r  <= PASS_FX;
            term_r  <= 1'b0;
            state_r <= ($signed(in_tdata[8*DATA_W-1:7*DATA_W]) >
                        $signed({1'b0, min_force_r})) ? ST_SETUP : ST_DONE;
          end
        end
        ST_SETUP: state_r <= ST_MUL;
        ST_MUL: begin
          if (mul_done) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (combined && !term_r) begin
            term_r  <= 1'b1;
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_DGO;
          end
        end
        ST_DGO: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          term_r <= 1'b0;
          unique case (pass_r)
            PASS_FX: begin
              pass_r  <= PASS_FY;
              state_r <= ST_SETUP;
            end
            PASS_FY: begin
              if (cmd_r == CMD_RIGHT && lload_r) begin
                pass_r  <= PASS_BX;
                state_r <= ST_SETUP;
              end else begin
                state_r <= ST_DONE;
              end
            end
            PASS_BX: begin
              pass_r  <= PASS_BY;
              state_r <= ST_SETUP;
            end
            PASS_BY: state_r <= ST_DONE;
            default: state_r <= ST_DONE;
          endcase
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
            // a left word replaces the kept left foot, loaded or not
            if (cmd_r != CMD_RIGHT) begin
              lload_r <= loaded_r;
              lcx_r   <= cx_r;
              lcy_r   <= cy_r;
              lfz_r   <= loaded_r ? fz_r : '0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // sample capture and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_tuser;
      px_r     <= in_tdata[1*DATA_W-1:0*DATA_W];
      py_r     <= in_tdata[2*DATA_W-1:1*DATA_W];
      pz_r     <= in_tdata[3*DATA_W-1:2*DATA_W];
      tx_r     <= in_tdata[4*DATA_W-1:3*DATA_W];
      ty_r     <= in_tdata[5*DATA_W-1:4*DATA_W];
      fx_r     <= in_tdata[6*DATA_W-1:5*DATA_W];
      fy_r     <= in_tdata[7*DATA_W-1:6*DATA_W];
      fz_r     <= in_tdata[8*DATA_W-1:7*DATA_W];
      loaded_r <= $signed(in_tdata[8*DATA_W-1:7*DATA_W]) > $signed({1'b0, min_force_r});
      cx_r     <= '0;
      cy_r     <= '0;
      bx_r     <= '0;
      by_r     <= '0;
      both_r   <= 1'b0;
      clip_r   <= 1'b0;
    end
    // sign of the product in flight, kept until it is accumulated
    if (mul_start) begin
      prod_neg_r <= prod_neg;
    end
    if (state_r == ST_SETUP) begin
      num_r <= num_base;
    end else if (state_r == ST_ACC) begin
      num_r <= prod_neg_r ? (num_r - prod) : (num_r + prod);
    end
    if (state_r == ST_FIN) begin
      clip_r <= clip_r | coord_ovf;
      unique case (pass_r)
        PASS_FX: cx_r <= coord_sat;
        PASS_FY: cy_r <= coord_sat;
        PASS_BX: bx_r <= coord_sat;
        PASS_BY: begin
          by_r   <= coord_sat;
          both_r <= 1'b1;
        end
        default: cx_r <= coord_sat;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                     clip_r, by_r, bx_r, both_r, cy_r, cx_r, loaded_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/bcop_chk.sv @@
// bcop_chk: port-level checks on the centre of pressure block, bound to the top level
// depends on bcop_pkg and biped_center_of_pressure
module bcop_chk import bcop_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a word still waiting keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // an unloaded foot reports zero coordinates
  a_foot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[2*DATA_W:1] == '0)
    else $error("unloaded foot with non-zero coordinates");

  // combined result only when this foot is loaded, zero otherwise
  a_both_needs_foot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2*DATA_W+1] |-> out_tdata[0])
    else $error("combined result on an unloaded foot");

  a_both_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2*DATA_W+1] |-> out_tdata[4*DATA_W+1:2*DATA_W+2] == '0)
    else $error("combined coordinates without both feet loaded");

  // a word taken at the input cannot produce its result in the next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared without processing time");

endmodule

bind biped_center_of_pressure bcop_chk u_bcop_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for biped_center_of_pressure, per-foot and combined cop
// depends on bcop_pkg and the block itself; predicts every result word from its own state

module testbench;
  import bcop_pkg::*;

  localparam int ONE_Q = 1 << FRAC_BITS;               // 1.0 in q16.16
  localparam int W_MAX = 32'h7fffffff;
  localparam int W_MIN = 32'h80000000;
  localparam int CYCLE_LIMIT = 1_000_000;              // watchdog limit
  localparam int TAIL_CYCLES = 400;                    // quiet time after the last result
  localparam int PRINT_CAP = 50;
  localparam longint WORD_MAX = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  localparam longint QUOT_LIM = longint'(1) << (DATA_W + 1);
  localparam logic [MF_W-1:0] THR_TOP = '1;

  typedef enum logic {FOOT_LEFT = 1'b0, FOOT_RIGHT = 1'b1} foot_side_t;

  // input word, first member sits in the top bits so pos_x lands at bit 0
  typedef struct packed {
    logic signed [DATA_W-1:0] force_z, force_y, force_x, torque_y, torque_x, pos_z, pos_y, pos_x;
  } ft_word_t;

  // result word, foot_valid at bit 0, zero pad on top
  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELD_W-1:0] pad;
    logic                               clipped;
    logic signed [DATA_W-1:0]           both_y, both_x;
    logic                               both_valid;
    logic signed [DATA_W-1:0]           foot_y, foot_x;
    logic                               foot_valid;
  } cop_word_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // pos_x, pos_y, pos_z, torque_x, torque_y,
                                       // force_x, force_y, force_z
  logic                   in_tuser;    // cmd: 0 left foot, 1 right foot
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // foot_valid, foot_x, foot_y, both_valid,
                                       // both_x, both_y, clipped, zero pad
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [MF_W-1:0]        cfg_data;

  // predictor state: threshold and the stored left foot
  logic [MF_W-1:0] thr_model;
  bit              lf_loaded;
  longint          lf_x, lf_y, lf_fz;

  cop_word_t cop_expected[$];          // predicted words, oldest first
  int        mismatches;
  int        results_seen;
  int        cycle_count;
  bit        tx_gaps;                  // sender idles between words
  bit        rx_gaps;                  // receiver stalls between words
  int        rx_hold_cycles;           // one long receiver hold-off, taken by the receiver

  biped_center_of_pressure u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------------------------

  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // position plus the truncated quotient, quotient held to +/-2^(DATA_W+1)
  function automatic longint axis_sum(longint pos, longint num, longint fz);
    longint q;
    q = num / fz;
    if (q > QUOT_LIM) q = QUOT_LIM;
    else if (q < -QUOT_LIM) q = -QUOT_LIM;
    return pos + q;
  endfunction

  // one foot word in, one result word out; updates the stored left foot
  function automatic cop_word_t cop_step(foot_side_t side, ft_word_t w);
    cop_word_t r;
    longint    px, py, pz, tx, ty, fx, fy, fz;
    longint    raw_x, raw_y, cx, cy, raw_bx, raw_by, total;
    bit        loaded;
    r  = '0;
    px = w.pos_x;    py = w.pos_y;    pz = w.pos_z;
    tx = w.torque_x; ty = w.torque_y;
    fx = w.force_x;  fy = w.force_y;  fz = w.force_z;
    cx = 0;
    cy = 0;
    // signed force against an unsigned threshold, so zero and negative never load
    loaded = fz > longint'(thr_model);
    if (loaded) begin
      raw_x = axis_sum(px, -ty * ONE_Q - pz * fx, fz);
      raw_y = axis_sum(py, tx * ONE_Q - pz * fy, fz);
      cx = clamp_word(raw_x);
      cy = clamp_word(raw_y);
      r.clipped = (cx != raw_x) || (cy != raw_y);
    end
    if (side == FOOT_LEFT) begin
      // an unloaded left clears what was stored
      lf_loaded = loaded;
      lf_x      = cx;
      lf_y      = cy;
      lf_fz     = loaded ? fz : 0;
    end else if (loaded && lf_loaded) begin
      // force-weighted mean of the two saturated feet
      total  = lf_fz + fz;
      raw_bx = (lf_fz * lf_x + fz * cx) / total;
      raw_by = (lf_fz * lf_y + fz * cy) / total;
      r.both_valid = 1'b1;
      r.both_x     = DATA_W'(clamp_word(raw_bx));
      r.both_y     = DATA_W'(clamp_word(raw_by));
      if (clamp_word(raw_bx) != raw_bx || clamp_word(raw_by) != raw_by) r.clipped = 1'b1;
    end
    r.foot_valid = loaded;
    r.foot_x     = DATA_W'(cx);
    r.foot_y     = DATA_W'(cy);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------------------------

  function automatic ft_word_t ft_pack(int px, int py, int pz, int tx, int ty,
                                       int fx, int fy, int fz);
    ft_word_t w;
    w.pos_x    = px; w.pos_y    = py; w.pos_z   = pz;
    w.torque_x = tx; w.torque_y = ty;
    w.force_x  = fx; w.force_y  = fy; w.force_z = fz;
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] corner_val();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3:       return W_MAX;
      4:       return W_MIN;
      default: return $urandom;
    endcase
  endfunction

  // mostly plausible stance data around the current threshold, some noise and corners
  function automatic ft_word_t draw_ft();
    ft_word_t    w;
    int unsigned pick;
    longint      fz;
    pick = $urandom_range(0, 99);
    if (pick >= 95) begin
      w = {corner_val(), corner_val(), corner_val(), corner_val(),
           corner_val(), corner_val(), corner_val(), corner_val()};
    end else if (pick >= 85) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      w.pos_x    = int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
      w.pos_y    = int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
      w.pos_z    = $urandom_range(0, ONE_Q / 4);
      w.torque_x = int'($urandom_range(0, 100 * ONE_Q)) - 50 * ONE_Q;
      w.torque_y = int'($urandom_range(0, 100 * ONE_Q)) - 50 * ONE_Q;
      w.force_x  = int'($urandom_range(0, 200 * ONE_Q)) - 100 * ONE_Q;
      w.force_y  = int'($urandom_range(0, 200 * ONE_Q)) - 100 * ONE_Q;
      if (pick < 60) begin
        // loaded, now and then exactly one lsb over the threshold
        fz = longint'(thr_model) + 1;
        if ($urandom_range(0, 7) != 0) fz += $urandom_range(0, 800 * ONE_Q);
        if (fz > WORD_MAX) fz = WORD_MAX;
      end else begin
        // at or just under the threshold, sometimes negative
        fz = longint'(thr_model) - $urandom_range(0, 20 * ONE_Q);
      end
      w.force_z = DATA_W'(fz);
    end
    if ($urandom_range(0, 14) == 0) tx_gaps = $urandom_range(0, 3) != 0;
    if ($urandom_range(0, 14) == 0) rx_gaps = $urandom_range(0, 3) != 0;
    return w;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------------------------

  // valid stays high from one word to the next when there is no gap
  task automatic send_ft(foot_side_t side, ft_word_t w);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= side;
    do @(posedge clk); while (!in_tready);
    cop_expected.push_back(cop_step(side, w));
  endtask

  task automatic hold_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (cop_expected.size() != 0) @(posedge clk);
  endtask

  // every word causes a result, so an empty queue means the block is idle
  task automatic write_threshold(logic [MF_W-1:0] v);
    hold_input();
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = v;
  endtask

  task automatic note_mismatch(string what);
    if (mismatches < PRINT_CAP) $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic cmp_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
  endtask

  // receiver: random stalls, one long hold-off on request, checks each word against the oldest
  initial begin
    int        stall;
    cop_word_t got;
    cop_word_t want;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_gaps ? $urandom_range(0, 11) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata;
      if (cop_expected.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = cop_expected.pop_front();
        cmp_field("foot_valid", got.foot_valid, want.foot_valid);
        cmp_field("foot_x", got.foot_x, want.foot_x);
        cmp_field("foot_y", got.foot_y, want.foot_y);
        cmp_field("both_valid", got.both_valid, want.both_valid);
        cmp_field("both_x", got.both_x, want.both_x);
        cmp_field("both_y", got.both_y, want.both_y);
        cmp_field("clipped", got.clipped, want.clipped);
      end
      results_seen++;
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------------

  // threshold as left by reset (10 n): threshold edges and left/right ordering
  task automatic test_reset_threshold();
    // right first, nothing stored for the left
    send_ft(FOOT_RIGHT, ft_pack(ONE_Q/10, -ONE_Q/20, ONE_Q/20, 2*ONE_Q, -3*ONE_Q,
                                5*ONE_Q, -4*ONE_Q, 100*ONE_Q));
    // force equal to the threshold is not loaded
    send_ft(FOOT_LEFT, ft_pack(ONE_Q/5, ONE_Q/10, ONE_Q/20, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 10*ONE_Q));
    send_ft(FOOT_RIGHT, ft_pack(-ONE_Q/5, ONE_Q/3, 0, -ONE_Q, ONE_Q/2, 0, 2*ONE_Q, 200*ONE_Q));
    // one lsb over on both feet
    send_ft(FOOT_LEFT, ft_pack(ONE_Q/4, -ONE_Q/8, ONE_Q/16, 3*ONE_Q, -2*ONE_Q,
                               ONE_Q, -ONE_Q, 10*ONE_Q + 1));
    send_ft(FOOT_RIGHT, ft_pack(-ONE_Q/4, ONE_Q/8, ONE_Q/16, -ONE_Q, 2*ONE_Q,
                                -3*ONE_Q, ONE_Q, 10*ONE_Q + 1));
    // second right in a row reuses the stored left
    send_ft(FOOT_RIGHT, ft_pack(ONE_Q/2, ONE_Q/2, ONE_Q/10, 20*ONE_Q, -20*ONE_Q,
                                30*ONE_Q, -30*ONE_Q, 300*ONE_Q));
    // two lefts, the later one wins
    send_ft(FOOT_LEFT, ft_pack(ONE_Q, ONE_Q, 0, 5*ONE_Q, 5*ONE_Q, 0, 0, 50*ONE_Q));
    send_ft(FOOT_LEFT, ft_pack(-ONE_Q, -ONE_Q, ONE_Q/10, -5*ONE_Q, 7*ONE_Q,
                               10*ONE_Q, 10*ONE_Q, 80*ONE_Q));
    send_ft(FOOT_RIGHT, ft_pack(ONE_Q/3, -ONE_Q/3, ONE_Q/10, ONE_Q, ONE_Q,
                                -10*ONE_Q, 5*ONE_Q, 120*ONE_Q));
    // negative force clears the stored left
    send_ft(FOOT_LEFT, ft_pack(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, -100*ONE_Q));
    send_ft(FOOT_RIGHT, ft_pack(0, 0, 0, ONE_Q, ONE_Q, 0, 0, 100*ONE_Q));
    // zero force
    send_ft(FOOT_LEFT, ft_pack(ONE_Q, -ONE_Q, 0, ONE_Q, -ONE_Q, ONE_Q, -ONE_Q, 0));
  endtask

  // field extremes with the threshold at both ends of its range
  task automatic test_field_extremes();
    write_threshold('0);
    // smallest load with everything at the negative end, quotient held and saturated
    send_ft(FOOT_LEFT, ft_pack(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1));
    send_ft(FOOT_RIGHT, ft_pack(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
    // torque pushes x over the top and y under the bottom
    send_ft(FOOT_LEFT, ft_pack(W_MAX, W_MAX, 0, W_MIN, W_MIN, 0, 0, 1));
    send_ft(FOOT_RIGHT, ft_pack(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX));
    // most negative force, unloaded
    send_ft(FOOT_LEFT, ft_pack(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN));
    // height term on its own
    send_ft(FOOT_RIGHT, ft_pack(0, 0, W_MIN, 0, 0, W_MAX, W_MIN, 1));
    // zero force against a zero threshold
    send_ft(FOOT_LEFT, ft_pack(-1, -1, -1, -1, -1, -1, -1, 0));
    send_ft(FOOT_RIGHT, ft_pack(-1, -1, -1, -1, -1, -1, -1, 1));
    // top threshold: even the largest force is not over it
    write_threshold(THR_TOP);
    send_ft(FOOT_LEFT, ft_pack(ONE_Q, ONE_Q, 0, ONE_Q, ONE_Q, 0, 0, W_MAX));
    send_ft(FOOT_RIGHT, ft_pack(-ONE_Q, ONE_Q, 0, ONE_Q, -ONE_Q, 0, 0, W_MAX));
  endtask

  // mostly left/right pairs, with the odd lone left or lone right
  task automatic test_random_feet(int n);
    int          sent;
    int unsigned shape;
    sent = 0;
    while (sent < n) begin
      shape = $urandom_range(0, 9);
      if (shape != 9) begin
        send_ft(FOOT_LEFT, draw_ft());
        sent++;
      end
      if (shape != 8) begin
        send_ft(FOOT_RIGHT, draw_ft());
        sent++;
      end
    end
  endtask

  // random stance data under several thresholds, ending back at the reset value
  task automatic test_threshold_sweep();
    write_threshold('0);
    test_random_feet(70);
    write_threshold(MF_W'(1));
    test_random_feet(50);
    write_threshold(MF_W'($urandom_range(0, 300 * ONE_Q)));
    test_random_feet(90);
    write_threshold(MF_W'($urandom_range(0, W_MAX)));
    test_random_feet(60);
    write_threshold(THR_TOP);
    test_random_feet(30);
    write_threshold(MIN_FORCE_RST);
    test_random_feet(90);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering back to back
  task automatic test_output_backpressure();
    hold_input();
    wait_drained();
    tx_gaps        = 1'b0;
    rx_hold_cycles = 1500;
    repeat (8) begin
      send_ft(FOOT_LEFT, draw_ft());
      send_ft(FOOT_RIGHT, draw_ft());
    end
    tx_gaps = 1'b1;
  endtask

  // sender stops until every word is back, then carries on
  task automatic test_drain_pause();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (5) begin
      send_ft(FOOT_LEFT, draw_ft());
      send_ft(FOOT_RIGHT, draw_ft());
    end
    hold_input();
    wait_drained();
    repeat (5) begin
      send_ft(FOOT_RIGHT, draw_ft());
      send_ft(FOOT_LEFT, draw_ft());
    end
  endtask

  initial begin
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    thr_model      = MIN_FORCE_RST;
    lf_loaded      = 1'b0;
    lf_x           = 0;
    lf_y           = 0;
    lf_fz          = 0;
    mismatches     = 0;
    results_seen   = 0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    rx_hold_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_threshold();
    test_field_extremes();
    test_threshold_sweep();
    test_output_backpressure();
    test_drain_pause();

    // let everything come back, then watch a while for strays
    hold_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ biped_center_of_pressure.f @@
hw/rtl/bcop_pkg.sv
hw/rtl/bcop_mul.sv
hw/rtl/bcop_div.sv
hw/rtl/biped_center_of_pressure.sv
hw/rtl/bcop_chk.sv
test/testbench.sv
